FILE: sv/sto_pkg.sv
package sto_pkg;

   localparam int BAR_PRICE_W = 32;
   localparam int DATE_W      = 63;
   localparam int PCT_W       = 15;
   localparam int KLEN_RAW_W  = 7;
   localparam int DLEN_RAW_W  = 5;
   localparam int CSR_DATA_W  = 7;

   localparam int MAX_K_WINDOW_DEF = 64;
   localparam int MAX_D_LENGTH_DEF = 16;
   localparam int PRICE_BITS_DEF   = 32;

   localparam logic [KLEN_RAW_W-1:0] KLEN_RESET = 7'd14;
   localparam logic [DLEN_RAW_W-1:0] DLEN_RESET = 5'd3;

   localparam logic [PCT_W-1:0] FULL_SCALE = 15'd25600;
   localparam logic [PCT_W-1:0] HALF_SCALE = 15'd12800;

   typedef enum logic [0:0] {
      CSR_K_WINDOW = 1'b0,
      CSR_D_LENGTH = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [BAR_PRICE_W-1:0] bar_high;
      logic [BAR_PRICE_W-1:0] bar_low;
      logic [BAR_PRICE_W-1:0] bar_close;
      logic [DATE_W-1:0]      date_tag;
   } bar_in_type;

   typedef struct packed {
      logic [DATE_W-1:0] result_date;
      logic [PCT_W-1:0]  k_percent;
      logic              k_ok;
      logic [PCT_W-1:0]  d_percent;
      logic              d_ok;
   } bar_out_type;

endpackage

FILE: sv/stochastic_oscillator_top.sv
// Stochastic oscillator %K / %D over a stream of price bars.
// req_*: one bar (high, low, close, date tag) per transfer, valid/ready.
// rsp_*: one result per bar (date, %K, %D in 1/256 percent, valid flags).
// csr_*: write-only registers: index CSR_K_WINDOW sets the lookback length,
//   CSR_D_LENGTH the %D average length. A write restarts the stream.
// One bar is processed at a time. Before the window fills a bar goes
// straight to the result. Once it fills, the window is rescanned one entry
// per cycle from the price history memory (one write and one read port),
// then a 15-step shift/subtract divider produces %K and is reused for the
// %D mean; each divide is skipped where not needed (%K at a range or clamp
// limit, %D not yet valid).
// The result sits in an output register; the next bar is taken while it
// waits. A stalled receiver only holds a finished result at the last step.
// Reset (synchronous) restores the default lengths and empties the history;
// memory contents are not cleared, entries are read only after written.
module stochastic_oscillator_top import sto_pkg::*; #(
   parameter int MAX_K_WINDOW = MAX_K_WINDOW_DEF,
   parameter int MAX_D_LENGTH = MAX_D_LENGTH_DEF,
   parameter int PRICE_BITS   = PRICE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bar_in_type            req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bar_out_type           rsp_data,
   input  logic                  csr_we,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW   = (MAX_K_WINDOW > 1) ? $clog2(MAX_K_WINDOW) : 1;
   localparam int DAW  = (MAX_D_LENGTH > 1) ? $clog2(MAX_D_LENGTH) : 1;
   localparam int KLW  = $clog2(MAX_K_WINDOW + 1);
   localparam int DLW  = $clog2(MAX_D_LENGTH + 1);
   localparam int SW   = $clog2(MAX_D_LENGTH * 25600 + 1);
   localparam int P    = PRICE_BITS;
   localparam int XW   = PRICE_BITS + BAR_PRICE_W;
   localparam int NW   = (P + PCT_W > SW) ? P + PCT_W : SW;
   localparam int RW   = (P > DLW) ? P : DLW;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_SCAN  = 9'b000000010,
      ST_KPREP = 9'b000000100,
      ST_KCALC = 9'b000001000,
      ST_KDIV  = 9'b000010000,
      ST_DREAD = 9'b000100000,
      ST_DUPD  = 9'b001000000,
      ST_DDIV  = 9'b010000000,
      ST_FIN   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [KLEN_RAW_W-1:0] klen_raw_ff, klen_raw_in;
   logic [DLEN_RAW_W-1:0] dlen_raw_ff, dlen_raw_in;
   logic [AW-1:0]         bwi_ff, bwi_in;
   logic [KLW-1:0]        bars_ff, bars_in;
   logic [DAW-1:0]        kwi_ff, kwi_in;
   logic [DLW-1:0]        kseen_ff, kseen_in;
   logic [SW-1:0]         sum_ff, sum_in;
   logic [P-1:0]          close_ff, close_in;
   logic [DATE_W-1:0]     date_ff, date_in;
   logic [AW-1:0]         rp_ff, rp_in;
   logic [KLW-1:0]        cnt_ff, cnt_in;
   logic                  rv_ff, rv_in;
   logic                  rfirst_ff, rfirst_in;
   logic [P-1:0]          hh_ff, hh_in;
   logic [P-1:0]          ll_ff, ll_in;
   logic signed [P:0]     num_ff, num_in;
   logic signed [P:0]     rng_ff, rng_in;
   logic [PCT_W-1:0]      kval_ff, kval_in;
   logic                  kok_ff, kok_in;
   logic [PCT_W-1:0]      dval_ff, dval_in;
   logic                  dok_ff, dok_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   bar_out_type           rsp_data_ff, rsp_data_in;

   logic [2*P-1:0]   bar_mem [MAX_K_WINDOW];
   logic [2*P-1:0]   bar_q_ff;
   logic             bar_we;
   logic [2*P-1:0]   bar_wdata;
   logic [PCT_W-1:0] k_mem [MAX_D_LENGTH];
   logic [PCT_W-1:0] k_q_ff;
   logic             k_we;
   logic [DAW-1:0]   k_raddr;

   logic [KLW-1:0]   klen;
   logic [DLW-1:0]   dlen;
   logic [XW-1:0]    hx, lx, cx;
   logic [P-1:0]     in_high, in_low, in_close;
   logic [KLW-1:0]   bars_new;
   logic [P-1:0]     q_high, q_low;
   logic             neg;
   logic signed [P:0] n_abs, r_abs;
   logic [P+4:0]     n25;
   logic [P+14:0]    kdividend;
   logic [DAW-1:0]   kwi_eff;
   logic [PCT_W-1:0] k_old;
   logic [SW-1:0]    sum_new;
   logic [DLW-1:0]   kseen_new;
   logic             div_start;
   logic [NW-1:0]    div_dividend;
   logic [RW-1:0]    div_divisor;
   logic             div_done;
   logic [PCT_W-1:0] div_q;

   assign klen = (klen_raw_ff == '0) ? KLW'(1) :
                 ((32'(klen_raw_ff) > 32'(MAX_K_WINDOW)) ? KLW'(MAX_K_WINDOW) :
                  KLW'(klen_raw_ff));
   assign dlen = (dlen_raw_ff == '0) ? DLW'(1) :
                 ((32'(dlen_raw_ff) > 32'(MAX_D_LENGTH)) ? DLW'(MAX_D_LENGTH) :
                  DLW'(dlen_raw_ff));

   assign hx       = XW'(req_data.bar_high);
   assign lx       = XW'(req_data.bar_low);
   assign cx       = XW'(req_data.bar_close);
   assign in_high  = hx[P-1:0];
   assign in_low   = lx[P-1:0];
   assign in_close = cx[P-1:0];
   assign bar_wdata = {in_high, in_low};
   assign bars_new  = (bars_ff < klen) ? bars_ff + KLW'(1) : bars_ff;

   assign q_high = bar_q_ff[2*P-1:P];
   assign q_low  = bar_q_ff[P-1:0];

   assign neg       = rng_ff[P];
   assign n_abs     = neg ? -num_ff : num_ff;
   assign r_abs     = neg ? -rng_ff : rng_ff;
   assign n25       = ((P+5)'(n_abs[P-1:0]) << 4) + ((P+5)'(n_abs[P-1:0]) << 3) +
                      (P+5)'(n_abs[P-1:0]);
   assign kdividend = {n25, 10'b0};

   assign kwi_eff   = (DLW'(kwi_ff) >= dlen) ? '0 : kwi_ff;
   assign k_raddr   = kwi_eff;
   assign k_old     = (kseen_ff >= dlen) ? k_q_ff : '0;
   assign sum_new   = sum_ff - SW'(k_old) + SW'(kval_ff);
   assign kseen_new = (kseen_ff < dlen) ? kseen_ff + DLW'(1) : kseen_ff;

   assign div_dividend = (state_ff == ST_KCALC) ? NW'(kdividend) : NW'(sum_new);
   assign div_divisor  = (state_ff == ST_KCALC) ? RW'(r_abs[P-1:0]) : RW'(dlen);

   always_comb begin
      state_in     = state_ff;
      klen_raw_in  = klen_raw_ff;
      dlen_raw_in  = dlen_raw_ff;
      bwi_in       = bwi_ff;
      bars_in      = bars_ff;
      kwi_in       = kwi_ff;
      kseen_in     = kseen_ff;
      sum_in       = sum_ff;
      close_in     = close_ff;
      date_in      = date_ff;
      rp_in        = rp_ff;
      cnt_in       = cnt_ff;
      rv_in        = 1'b0;
      rfirst_in    = 1'b0;
      hh_in        = hh_ff;
      ll_in        = ll_ff;
      num_in       = num_ff;
      rng_in       = rng_ff;
      kval_in      = kval_ff;
      kok_in       = kok_ff;
      dval_in      = dval_ff;
      dok_in       = dok_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      bar_we       = 1'b0;
      k_we         = 1'b0;
      div_start    = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               bar_we   = 1'b1;
               bwi_in   = (bwi_ff == AW'(MAX_K_WINDOW - 1)) ? '0 : bwi_ff + AW'(1);
               bars_in  = bars_new;
               close_in = in_close;
               date_in  = req_data.date_tag;
               rp_in    = bwi_ff;
               cnt_in   = '0;
               kval_in  = '0;
               dval_in  = '0;
               dok_in   = 1'b0;
               if (bars_new >= klen) begin
                  kok_in   = 1'b1;
                  state_in = ST_SCAN;
               end else begin
                  kok_in   = 1'b0;
                  state_in = ST_FIN;
               end
            end
         end
         ST_SCAN: begin
            if (cnt_ff < klen) begin
               rv_in     = 1'b1;
               rfirst_in = (cnt_ff == '0);
               cnt_in    = cnt_ff + KLW'(1);
               rp_in     = (rp_ff == '0) ? AW'(MAX_K_WINDOW - 1) : rp_ff - AW'(1);
            end
            if (rv_ff) begin
               if (rfirst_ff || q_high > hh_ff) begin
                  hh_in = q_high;
               end
               if (rfirst_ff || q_low < ll_ff) begin
                  ll_in = q_low;
               end
            end else if (cnt_ff == klen) begin
               state_in = ST_KPREP;
            end
         end
         ST_KPREP: begin
            num_in   = $signed({1'b0, close_ff}) - $signed({1'b0, ll_ff});
            rng_in   = $signed({1'b0, hh_ff}) - $signed({1'b0, ll_ff});
            state_in = ST_KCALC;
         end
         ST_KCALC: begin
            if (rng_ff == '0) begin
               kval_in  = HALF_SCALE;
               state_in = ST_DREAD;
            end else if (n_abs <= 0) begin
               kval_in  = '0;
               state_in = ST_DREAD;
            end else if (n_abs >= r_abs) begin
               kval_in  = FULL_SCALE;
               state_in = ST_DREAD;
            end else begin
               div_start = 1'b1;
               state_in  = ST_KDIV;
            end
         end
         ST_KDIV: begin
            if (div_done) begin
               kval_in  = div_q;
               state_in = ST_DREAD;
            end
         end
         ST_DREAD: begin
            kwi_in   = kwi_eff;
            state_in = ST_DUPD;
         end
         ST_DUPD: begin
            k_we     = 1'b1;
            sum_in   = sum_new;
            kseen_in = kseen_new;
            kwi_in   = ((DLW'(kwi_ff) + DLW'(1)) == dlen) ? '0 : kwi_ff + DAW'(1);
            if (kseen_new >= dlen) begin
               dok_in    = 1'b1;
               div_start = 1'b1;
               state_in  = ST_DDIV;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_DDIV: begin
            if (div_done) begin
               dval_in  = div_q;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.result_date = date_ff;
               rsp_data_in.k_percent   = kval_ff;
               rsp_data_in.k_ok        = kok_ff;
               rsp_data_in.d_percent   = dval_ff;
               rsp_data_in.d_ok        = dok_ff;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         unique case (csr_index)
            CSR_K_WINDOW: klen_raw_in = csr_wdata[KLEN_RAW_W-1:0];
            CSR_D_LENGTH: dlen_raw_in = csr_wdata[DLEN_RAW_W-1:0];
            default:      klen_raw_in = klen_raw_ff;
         endcase
         bwi_in   = '0;
         bars_in  = '0;
         kwi_in   = '0;
         kseen_in = '0;
         sum_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         klen_raw_ff  <= KLEN_RESET;
         dlen_raw_ff  <= DLEN_RESET;
         bwi_ff       <= '0;
         bars_ff      <= '0;
         kwi_ff       <= '0;
         kseen_ff     <= '0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         rv_ff        <= 1'b0;
         rfirst_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         klen_raw_ff  <= klen_raw_in;
         dlen_raw_ff  <= dlen_raw_in;
         bwi_ff       <= bwi_in;
         bars_ff      <= bars_in;
         kwi_ff       <= kwi_in;
         kseen_ff     <= kseen_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         rv_ff        <= rv_in;
         rfirst_ff    <= rfirst_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      close_ff    <= close_in;
      date_ff     <= date_in;
      rp_ff       <= rp_in;
      hh_ff       <= hh_in;
      ll_ff       <= ll_in;
      num_ff      <= num_in;
      rng_ff      <= rng_in;
      kval_ff     <= kval_in;
      kok_ff      <= kok_in;
      dval_ff     <= dval_in;
      dok_ff      <= dok_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (bar_we) begin
         bar_mem[bwi_ff] <= bar_wdata;
      end
      bar_q_ff <= bar_mem[rp_ff];
   end

   always_ff @(posedge clock) begin
      if (k_we) begin
         k_mem[kwi_ff] <= kval_ff;
      end
      k_q_ff <= k_mem[k_raddr];
   end

   sto_div #(
      .NUM_W (NW),
      .DEN_W (RW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_k_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.k_percent <= FULL_SCALE &&
                        rsp_data_ff.d_percent <= FULL_SCALE))
      else $error("percent above full scale");

   a_k_gates_d: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.k_ok) |->
         (rsp_data_ff.k_percent == '0 && !rsp_data_ff.d_ok &&
          rsp_data_ff.d_percent == '0))
      else $error("k or d percent without valid window");

   a_bars_sat: assert property (@(posedge clock) disable iff (reset)
      bars_ff <= klen)
      else $error("bar count beyond window length");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_KDIV || state_ff == ST_DDIV))
      else $error("divider finished outside a divide step");

endmodule

FILE: sv/sto_div.sv
module sto_div import sto_pkg::*; #(
   parameter int NUM_W = 47,
   parameter int DEN_W = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [PCT_W-1:0] quotient
);

   localparam int EXT_W = (NUM_W > DEN_W + PCT_W) ? NUM_W : DEN_W + PCT_W;
   localparam int CNT_W = $clog2(PCT_W);

   logic [EXT_W-1:0] rem_ff, rem_in;
   logic [EXT_W-1:0] dsh_ff, dsh_in;
   logic [PCT_W-1:0] q_ff, q_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             ge;

   assign ge = (rem_ff >= dsh_ff);

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = EXT_W'(dividend);
         dsh_in  = EXT_W'(divisor) << (PCT_W - 1);
         q_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? (rem_ff - dsh_ff) : rem_ff;
         dsh_in = dsh_ff >> 1;
         q_in   = {q_ff[PCT_W-2:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(PCT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule
